### hdl/tacm_pkg.sv
// shared types, widths and helpers for the touch calibration map
package tacm_pkg;

  // coordinate field width inside a calibration register
  localparam int COORD_BITS = 12;

  // register file
  localparam int REG_W    = 24;
  localparam int NUM_REGS = 6;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int IDX_W    = ADDR_W - 2;

  // sample and result fields
  localparam int RAW_W = 12;
  localparam int OUT_W = 16;

  // arithmetic widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int DET_W   = 2 * COORD_BITS + 3;
  localparam int MIN_W   = 2 * COORD_BITS + 1;
  localparam int PROD_W  = DIFF_W + MIN_W;
  localparam int N3_W    = 3 * COORD_BITS + 4;
  localparam int SPROD_W = DET_W + RAW_W + 1;
  localparam int NUM_W   = ((SPROD_W > N3_W) ? SPROD_W : N3_W) + 2;

  // divider layout
  localparam int QBITS           = OUT_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QBITS / STEPS_PER_STAGE;
  localparam int HI_W            = NUM_W - QBITS;
  localparam int CMP_W           = (HI_W > DET_W) ? HI_W : DET_W;

  // clamp bounds of a result coordinate
  localparam logic [OUT_W-1:0] SCREEN_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SCREEN_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PANEL_ONE,
    REG_PANEL_TWO,
    REG_PANEL_THREE,
    REG_TOUCH_ONE,
    REG_TOUCH_TWO,
    REG_TOUCH_THREE
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

  // identity map after reset
  localparam cfg_regs_t CFG_RESET = {
    REG_W'(16773120), REG_W'(4095), REG_W'(0),
    REG_W'(16773120), REG_W'(4095), REG_W'(0)
  };

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    degenerate;
    logic                    saturated;
  } out_req_t;

  // per-lane coefficients, lane 0 is x and lane 1 is y
  typedef struct packed {
    logic [1:0][DET_W-1:0] n1;
    logic [1:0][DET_W-1:0] n2;
    logic [1:0][N3_W-1:0]  n3;
    logic [DET_W-1:0]      det_mag;
    logic                  det_neg;
    logic                  det_zero;
  } coef_t;

  function automatic logic [COORD_BITS-1:0] coord_x(input logic [REG_W-1:0] r);
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_y(input logic [REG_W-1:0] r);
    logic [REG_W-1:0] s;
    s = r >> COORD_BITS;
    return s[COORD_BITS-1:0];
  endfunction

endpackage

### hdl/tacm_regs.sv
// calibration register file behind the apb port
module tacm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tacm_pkg::ADDR_W-1:0]  paddr,
  input  logic [tacm_pkg::DATA_W-1:0]  pwdata,
  output logic [tacm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tacm_pkg::cfg_regs_t          cfg,
  output logic                         cfg_write
);
  import tacm_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx       = paddr[ADDR_W-1:2];
  assign wr        = psel && penable && pwrite;
  assign pready    = 1'b1;
  // any write restarts the coefficient pass
  assign cfg_write = wr;

  // register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr && (int'(idx) < NUM_REGS)) begin
      cfg[idx] <= pwdata[REG_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (int'(idx) < NUM_REGS) begin
      prdata = DATA_W'(cfg[idx]);
    end
  end

endmodule

### hdl/tacm_coef.sv
// coefficient engine: determinant and numerator terms on one shared multiplier
module tacm_coef (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tacm_pkg::cfg_regs_t cfg,
  output tacm_pkg::coef_t     coef,
  output logic                busy
);
  import tacm_pkg::*;

  localparam int NSTEPS = 22;
  localparam int STEP_W = $clog2(NSTEPS + 1);

  typedef enum logic [3:0] {
    A_D13X, A_D23X, A_TX1, A_TX2, A_TX3, A_PD13X, A_PD23X, A_PX1, A_PX2, A_PX3,
    A_PD13Y, A_PD23Y, A_PY1, A_PY2, A_PY3
  } a_sel_t;

  typedef enum logic [3:0] {
    B_D23Y, B_D13Y, B_D13X, B_D23X, B_TY1, B_TY2, B_TY3, B_M23, B_M13, B_M12
  } b_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_DET, D_M23, D_M13, D_M12, D_NX1, D_NX2, D_NX3, D_NY1, D_NY2, D_NY3
  } dest_t;

  typedef struct packed {
    logic  sub;
    logic  clr;
    dest_t dest;
  } acc_ctl_t;

  typedef struct packed {
    a_sel_t   a;
    b_sel_t   b;
    acc_ctl_t ctl;
  } step_t;

  function automatic step_t mk(input a_sel_t a, input b_sel_t b, input logic sub,
                               input logic clr, input dest_t dest);
    step_t s;
    s.a        = a;
    s.b        = b;
    s.ctl.sub  = sub;
    s.ctl.clr  = clr;
    s.ctl.dest = dest;
    return s;
  endfunction

  // microprogram: each entry is acc = (clr ? 0 : acc) +/- a*b
  function automatic step_t step_info(input logic [STEP_W-1:0] i);
    step_t s;
    unique case (i)
      STEP_W'(0):  s = mk(A_D13X,  B_D23Y, 1'b0, 1'b1, D_NONE);
      STEP_W'(1):  s = mk(A_D23X,  B_D13Y, 1'b1, 1'b0, D_DET);
      STEP_W'(2):  s = mk(A_TX2,   B_TY3,  1'b0, 1'b1, D_NONE);
      STEP_W'(3):  s = mk(A_TX3,   B_TY2,  1'b1, 1'b0, D_M23);
      STEP_W'(4):  s = mk(A_TX1,   B_TY3,  1'b0, 1'b1, D_NONE);
      STEP_W'(5):  s = mk(A_TX3,   B_TY1,  1'b1, 1'b0, D_M13);
      STEP_W'(6):  s = mk(A_TX1,   B_TY2,  1'b0, 1'b1, D_NONE);
      STEP_W'(7):  s = mk(A_TX2,   B_TY1,  1'b1, 1'b0, D_M12);
      STEP_W'(8):  s = mk(A_PD13X, B_D23Y, 1'b0, 1'b1, D_NONE);
      STEP_W'(9):  s = mk(A_PD23X, B_D13Y, 1'b1, 1'b0, D_NX1);
      STEP_W'(10): s = mk(A_PD23X, B_D13X, 1'b0, 1'b1, D_NONE);
      STEP_W'(11): s = mk(A_PD13X, B_D23X, 1'b1, 1'b0, D_NX2);
      STEP_W'(12): s = mk(A_PX1,   B_M23,  1'b0, 1'b1, D_NONE);
      STEP_W'(13): s = mk(A_PX2,   B_M13,  1'b1, 1'b0, D_NONE);
      STEP_W'(14): s = mk(A_PX3,   B_M12,  1'b0, 1'b0, D_NX3);
      STEP_W'(15): s = mk(A_PD13Y, B_D23Y, 1'b0, 1'b1, D_NONE);
      STEP_W'(16): s = mk(A_PD23Y, B_D13Y, 1'b1, 1'b0, D_NY1);
      STEP_W'(17): s = mk(A_PD23Y, B_D13X, 1'b0, 1'b1, D_NONE);
      STEP_W'(18): s = mk(A_PD13Y, B_D23X, 1'b1, 1'b0, D_NY2);
      STEP_W'(19): s = mk(A_PY1,   B_M23,  1'b0, 1'b1, D_NONE);
      STEP_W'(20): s = mk(A_PY2,   B_M13,  1'b1, 1'b0, D_NONE);
      STEP_W'(21): s = mk(A_PY3,   B_M12,  1'b0, 1'b0, D_NY3);
      default:     s = mk(A_D13X,  B_D23Y, 1'b0, 1'b0, D_NONE);
    endcase
    return s;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // sequencer
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic              op_v;
  logic              pr_v;
  step_t             st;

  // operand, product and accumulator stages
  logic signed [DIFF_W-1:0] a_val, a_op;
  logic signed [MIN_W-1:0]  b_val, b_op;
  logic signed [PROD_W-1:0] prod;
  acc_ctl_t                 ctl1, ctl2;
  logic signed [N3_W-1:0]   acc, acc_next, pe, base;

  // results
  logic signed [DET_W-1:0] det, nx1, nx2, ny1, ny2;
  logic signed [MIN_W-1:0] m23, m13, m12;
  logic signed [N3_W-1:0]  nx3, ny3;
  logic [DET_W-1:0]        det_mag;
  logic                    det_neg, det_zero;

  // coordinates and differences
  logic [COORD_BITS-1:0]    tx1, tx2, tx3, ty1, ty2, ty3;
  logic [COORD_BITS-1:0]    px1, px2, px3, py1, py2, py3;
  logic signed [DIFF_W-1:0] d13x, d23x, d13y, d23y, pd13x, pd23x, pd13y, pd23y;

  always_comb begin
    tx1 = coord_x(cfg[REG_TOUCH_ONE]);
    ty1 = coord_y(cfg[REG_TOUCH_ONE]);
    tx2 = coord_x(cfg[REG_TOUCH_TWO]);
    ty2 = coord_y(cfg[REG_TOUCH_TWO]);
    tx3 = coord_x(cfg[REG_TOUCH_THREE]);
    ty3 = coord_y(cfg[REG_TOUCH_THREE]);
    px1 = coord_x(cfg[REG_PANEL_ONE]);
    py1 = coord_y(cfg[REG_PANEL_ONE]);
    px2 = coord_x(cfg[REG_PANEL_TWO]);
    py2 = coord_y(cfg[REG_PANEL_TWO]);
    px3 = coord_x(cfg[REG_PANEL_THREE]);
    py3 = coord_y(cfg[REG_PANEL_THREE]);
    d13x  = sdiff(tx1, tx3);
    d23x  = sdiff(tx2, tx3);
    d13y  = sdiff(ty1, ty3);
    d23y  = sdiff(ty2, ty3);
    pd13x = sdiff(px1, px3);
    pd23x = sdiff(px2, px3);
    pd13y = sdiff(py1, py3);
    pd23y = sdiff(py2, py3);
  end

  assign st = step_info(cnt);

  // operand select
  always_comb begin
    unique case (st.a)
      A_D13X:  a_val = d13x;
      A_D23X:  a_val = d23x;
      A_TX1:   a_val = $signed({1'b0, tx1});
      A_TX2:   a_val = $signed({1'b0, tx2});
      A_TX3:   a_val = $signed({1'b0, tx3});
      A_PD13X: a_val = pd13x;
      A_PD23X: a_val = pd23x;
      A_PX1:   a_val = $signed({1'b0, px1});
      A_PX2:   a_val = $signed({1'b0, px2});
      A_PX3:   a_val = $signed({1'b0, px3});
      A_PD13Y: a_val = pd13y;
      A_PD23Y: a_val = pd23y;
      A_PY1:   a_val = $signed({1'b0, py1});
      A_PY2:   a_val = $signed({1'b0, py2});
      A_PY3:   a_val = $signed({1'b0, py3});
      default: a_val = '0;
    endcase
    unique case (st.b)
      B_D23Y:  b_val = MIN_W'(d23y);
      B_D13Y:  b_val = MIN_W'(d13y);
      B_D13X:  b_val = MIN_W'(d13x);
      B_D23X:  b_val = MIN_W'(d23x);
      B_TY1:   b_val = $signed(MIN_W'({1'b0, ty1}));
      B_TY2:   b_val = $signed(MIN_W'({1'b0, ty2}));
      B_TY3:   b_val = $signed(MIN_W'({1'b0, ty3}));
      B_M23:   b_val = m23;
      B_M13:   b_val = m13;
      B_M12:   b_val = m12;
      default: b_val = '0;
    endcase
  end

  // accumulate
  always_comb begin
    pe       = N3_W'(prod);
    base     = ctl2.clr ? '0 : acc;
    acc_next = ctl2.sub ? (base - pe) : (base + pe);
  end

  // sequencer control, restarted by reset and by every register write
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b1;
      cnt  <= '0;
      op_v <= 1'b0;
      pr_v <= 1'b0;
    end else begin
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(NSTEPS - 1)) begin
          run <= 1'b0;
        end
      end
      op_v <= run;
      pr_v <= op_v;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_op <= a_val;
    b_op <= b_val;
    ctl1 <= st.ctl;
    prod <= a_op * b_op;
    ctl2 <= ctl1;
    if (pr_v) begin
      acc <= acc_next;
      unique case (ctl2.dest)
        D_DET:   det <= acc_next[DET_W-1:0];
        D_M23:   m23 <= acc_next[MIN_W-1:0];
        D_M13:   m13 <= acc_next[MIN_W-1:0];
        D_M12:   m12 <= acc_next[MIN_W-1:0];
        D_NX1:   nx1 <= acc_next[DET_W-1:0];
        D_NX2:   nx2 <= acc_next[DET_W-1:0];
        D_NX3:   nx3 <= acc_next;
        D_NY1:   ny1 <= acc_next[DET_W-1:0];
        D_NY2:   ny2 <= acc_next[DET_W-1:0];
        D_NY3:   ny3 <= acc_next;
        default: ;
      endcase
    end
    // divisor magnitude and sign for the sample pipeline
    det_neg  <= det[DET_W-1];
    det_zero <= (det == '0);
    det_mag  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  end

  assign busy = run || op_v || pr_v;

  always_comb begin
    coef.n1[0]   = nx1;
    coef.n1[1]   = ny1;
    coef.n2[0]   = nx2;
    coef.n2[1]   = ny2;
    coef.n3[0]   = nx3;
    coef.n3[1]   = ny3;
    coef.det_mag = det_mag;
    coef.det_neg = det_neg;
    coef.det_zero = det_zero;
  end

endmodule

### hdl/tacm_map.sv
// sample pipeline: products, sum, magnitude, restoring divider, clamp
module tacm_map (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  tacm_pkg::coef_t   coef,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tacm_pkg::in_req_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tacm_pkg::out_req_t result
);
  import tacm_pkg::*;

  localparam int S_PROD = 0;
  localparam int S_SUM  = 1;
  localparam int S_MAG  = 2;
  localparam int S_INIT = 3;
  localparam int S_DIV  = 4;
  localparam int S_OUT  = S_DIV + DIV_STAGES;
  localparam int NST    = S_OUT + 1;

  localparam logic [QBITS-1:0] NEG_LIM = {1'b1, {(QBITS-1){1'b0}}};

  logic [NST-1:0] v;
  logic [NST:0]   rdy;
  logic           take;

  logic signed [SPROD_W-1:0] p1 [2];
  logic signed [SPROD_W-1:0] p2 [2];
  logic signed [NUM_W-1:0]   num [2];
  logic [NUM_W-1:0]          mag [2];
  logic                      mneg [2];

  logic [DET_W-1:0] dr   [DIV_STAGES+1][2];
  logic [QBITS-1:0] dq   [DIV_STAGES+1][2];
  logic             dneg [DIV_STAGES+1][2];
  logic             dovf [DIV_STAGES+1][2];

  logic [OUT_W-1:0] val [2];
  logic             big [2];
  out_req_t         res_nx;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[NST] = !result_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign sample_stall = hold || !rdy[S_PROD];
  assign take         = sample_valid && !sample_stall;
  assign result_valid = v[S_OUT];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[S_PROD]) begin
        v[S_PROD] <= take;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // products with the raw sample
  always_ff @(posedge clk) begin
    if (rdy[S_PROD]) begin
      for (int l = 0; l < 2; l++) begin
        p1[l] <= $signed(coef.n1[l]) * $signed({1'b0, sample.raw_x});
        p2[l] <= $signed(coef.n2[l]) * $signed({1'b0, sample.raw_y});
      end
    end
  end

  // numerator sum
  always_ff @(posedge clk) begin
    if (rdy[S_SUM]) begin
      for (int l = 0; l < 2; l++) begin
        num[l] <= NUM_W'(p1[l]) + NUM_W'(p2[l]) + NUM_W'($signed(coef.n3[l]));
      end
    end
  end

  // magnitude and quotient sign
  always_ff @(posedge clk) begin
    if (rdy[S_MAG]) begin
      for (int l = 0; l < 2; l++) begin
        mag[l]  <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
        mneg[l] <= num[l][NUM_W-1] ^ coef.det_neg;
      end
    end
  end

  // overflow check and divider seed: high part is the first partial remainder
  always_ff @(posedge clk) begin
    if (rdy[S_INIT]) begin
      for (int l = 0; l < 2; l++) begin
        dr[0][l]   <= DET_W'(mag[l][NUM_W-1:QBITS]);
        dq[0][l]   <= mag[l][QBITS-1:0];
        dovf[0][l] <= CMP_W'(mag[l][NUM_W-1:QBITS]) >= CMP_W'(coef.det_mag);
        dneg[0][l] <= mneg[l];
      end
    end
  end

  // restoring divider, quotient bits shift in as dividend bits shift out
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [DET_W-1:0] r_nx [2];
    logic [QBITS-1:0] q_nx [2];

    always_comb begin
      logic [DET_W:0] t;
      for (int l = 0; l < 2; l++) begin
        r_nx[l] = dr[g][l];
        q_nx[l] = dq[g][l];
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
          t = {r_nx[l], q_nx[l][QBITS-1]};
          if (t >= {1'b0, coef.det_mag}) begin
            r_nx[l] = DET_W'(t - {1'b0, coef.det_mag});
            q_nx[l] = {q_nx[l][QBITS-2:0], 1'b1};
          end else begin
            r_nx[l] = t[DET_W-1:0];
            q_nx[l] = {q_nx[l][QBITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[S_DIV+g]) begin
        for (int l = 0; l < 2; l++) begin
          dr[g+1][l]   <= r_nx[l];
          dq[g+1][l]   <= q_nx[l];
          dneg[g+1][l] <= dneg[g][l];
          dovf[g+1][l] <= dovf[g][l];
        end
      end
    end
  end

  // sign, clamp and collinear case
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big[l] = dovf[DIV_STAGES][l] ||
               (!dneg[DIV_STAGES][l] && dq[DIV_STAGES][l][QBITS-1]) ||
               (dneg[DIV_STAGES][l] && (dq[DIV_STAGES][l] > NEG_LIM));
      if (big[l]) begin
        val[l] = dneg[DIV_STAGES][l] ? SCREEN_MIN : SCREEN_MAX;
      end else if (dneg[DIV_STAGES][l]) begin
        val[l] = OUT_W'(~dq[DIV_STAGES][l] + 1'b1);
      end else begin
        val[l] = OUT_W'(dq[DIV_STAGES][l]);
      end
    end
    res_nx.screen_x   = coef.det_zero ? '0 : val[0];
    res_nx.screen_y   = coef.det_zero ? '0 : val[1];
    res_nx.degenerate = coef.det_zero;
    res_nx.saturated  = !coef.det_zero && (big[0] || big[1]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      result <= res_nx;
    end
  end

endmodule

### hdl/touch_affine_calibration_map_core.sv
// top level of the three-point touch calibration map
//
//   channel   dir  handshake               payload
//   sample    in   sample_valid/stall      in_req_t  {raw_x, raw_y}
//   result    out  result_valid/stall      out_req_t {screen_x, screen_y, degenerate, saturated}
//   config    in   apb psel/penable/pready six 24-bit registers at 4*i
//
// one sample per cycle sustained unless result is stalled or a coefficient pass runs;
// the 16-step restoring divider produces two quotient bits per stage
// after reset and after every register write the coefficient engine runs a
// 22-step pass on its one multiplier, with sample stalled
// every stage has its own valid bit, so bubbles close up while result is stalled
module touch_affine_calibration_map_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  tacm_pkg::in_req_t            sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output tacm_pkg::out_req_t           result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tacm_pkg::ADDR_W-1:0]  paddr,
  input  logic [tacm_pkg::DATA_W-1:0]  pwdata,
  output logic [tacm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tacm_pkg::*;

  cfg_regs_t cfg;
  coef_t     coef;
  logic      cfg_write;
  logic      busy;

  // register file
  tacm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .cfg_write (cfg_write)
  );

  // coefficients from the calibration points
  tacm_coef u_coef (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_write),
    .cfg   (cfg),
    .coef  (coef),
    .busy  (busy)
  );

  // per-sample pipeline
  tacm_map u_map (
    .clk          (clk),
    .rst          (rst),
    .hold         (busy),
    .coef         (coef),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### hdl/tacm_check.sv
// port-level checks for the touch calibration map, bound to the top level
module tacm_check (
  input logic                clk,
  input logic                rst,
  input logic                sample_stall,
  input logic                result_valid,
  input logic                result_stall,
  input tacm_pkg::out_req_t  result,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic                pready
);
  import tacm_pkg::*;

  // a stalled request holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result request changed while stalled");

  // collinear points give zero coordinates and no clamp
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.screen_x == '0 && result.screen_y == '0 && !result.saturated)
    else $error("degenerate result with nonzero fields");

  // a clamp leaves a coordinate at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.screen_x == SCREEN_MAX || result.screen_x == SCREEN_MIN ||
      result.screen_y == SCREEN_MAX || result.screen_y == SCREEN_MIN)
    else $error("saturated flag without clamped coordinate");

  // coefficients are recomputed after reset and every write
  a_recalc_stall: assert property (@(posedge clk)
    rst || (psel && penable && pwrite && pready) |=> sample_stall)
    else $error("sample taken during coefficient pass");

endmodule

bind touch_affine_calibration_map_core tacm_check u_check (.*);

### dv/touch_affine_calibration_map_core_tb.sv
// self-checking testbench for the three-point touch calibration map core
module touch_affine_calibration_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tacm_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 75;

  // indexes past the register file, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED_A = IDX_W'(NUM_REGS);
  localparam logic [IDX_W-1:0] REG_UNUSED_B = IDX_W'(NUM_REGS + 1);

  typedef enum int {FLOW_OPEN, FLOW_CHOPPY, FLOW_SPARSE} flow_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  in_req_t           sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_req_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of the calibration registers
  logic [REG_W-1:0] cal_regs [NUM_REGS];
  in_req_t          sample_queue [$];
  out_req_t         mapped_q [$];
  int               errors = 0;
  logic             sample_taken = 1'b0;
  logic             hold_go = 1'b0;

  touch_affine_calibration_map_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // clamp a quotient to the 16-bit screen range
  function automatic logic [OUT_W-1:0] clamp_coord(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return SCREEN_MAX;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return SCREEN_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

  // affine map of one raw sample under the current calibration
  function automatic out_req_t map_sample(input in_req_t s);
    longint   px [3];
    longint   py [3];
    longint   tx [3];
    longint   ty [3];
    longint   rx, ry, delta, m23, m13, m12;
    longint   nx1, nx2, nx3, ny1, ny2, ny3;
    logic     sat;
    out_req_t r;
    int       k;
    for (k = 0; k < 3; k++) begin
      px[k] = cal_regs[REG_PANEL_ONE + k][COORD_BITS-1:0];
      py[k] = cal_regs[REG_PANEL_ONE + k][2*COORD_BITS-1:COORD_BITS];
      tx[k] = cal_regs[REG_TOUCH_ONE + k][COORD_BITS-1:0];
      ty[k] = cal_regs[REG_TOUCH_ONE + k][2*COORD_BITS-1:COORD_BITS];
    end
    rx = s.raw_x;
    ry = s.raw_y;
    delta = (tx[0] - tx[2]) * (ty[1] - ty[2]) - (tx[1] - tx[2]) * (ty[0] - ty[2]);
    m23 = tx[1] * ty[2] - tx[2] * ty[1];
    m13 = tx[0] * ty[2] - tx[2] * ty[0];
    m12 = tx[0] * ty[1] - tx[1] * ty[0];
    nx1 = (px[0] - px[2]) * (ty[1] - ty[2]) - (px[1] - px[2]) * (ty[0] - ty[2]);
    nx2 = (tx[0] - tx[2]) * (px[1] - px[2]) - (tx[1] - tx[2]) * (px[0] - px[2]);
    nx3 = px[0] * m23 - px[1] * m13 + px[2] * m12;
    ny1 = (py[0] - py[2]) * (ty[1] - ty[2]) - (py[1] - py[2]) * (ty[0] - ty[2]);
    ny2 = (tx[0] - tx[2]) * (py[1] - py[2]) - (tx[1] - tx[2]) * (py[0] - py[2]);
    ny3 = py[0] * m23 - py[1] * m13 + py[2] * m12;
    r = '0;
    sat = 1'b0;
    if (delta == 0) begin
      r.degenerate = 1'b1;
    end else begin
      // signed division truncates toward zero
      r.screen_x = clamp_coord((nx1 * rx + nx2 * ry + nx3) / delta, sat);
      r.screen_y = clamp_coord((ny1 * rx + ny2 * ry + ny3) / delta, sat);
      r.saturated = sat;
    end
    return r;
  endfunction

  function automatic logic [REG_W-1:0] cal_point(input int x, input int y);
    return {y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
  endfunction

  function automatic int jitter(input int c, input int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // raw reading, biased toward the converter extremes
  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
    endcase
  endfunction

  function automatic in_req_t raw_req(input int x, input int y);
    in_req_t s;
    s.raw_x = x[RAW_W-1:0];
    s.raw_y = y[RAW_W-1:0];
    return s;
  endfunction

  // one apb transfer, setup then access
  task automatic apb_access(input logic wr, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cal_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    logic [DATA_W-1:0] junk;
    // upper data bits are noise the register must drop
    apb_access(1'b1, idx, {(DATA_W-REG_W)'($urandom), value}, junk);
    if (idx < NUM_REGS) cal_regs[idx] = value;
  endtask

  task automatic check_readback();
    logic [DATA_W-1:0] rd;
    int                k;
    for (k = 0; k < NUM_REGS; k++) begin
      apb_access(1'b0, k[IDX_W-1:0], '0, rd);
      if (rd !== DATA_W'(cal_regs[k])) begin
        errors++;
        $display("%0t: register %0d read expected %h got %h", $time, k, cal_regs[k], rd);
      end
    end
  endtask

  task automatic load_calibration(input logic [REG_W-1:0] p1, p2, p3, t1, t2, t3);
    cal_write(REG_PANEL_ONE, p1);
    cal_write(REG_PANEL_TWO, p2);
    cal_write(REG_PANEL_THREE, p3);
    cal_write(REG_TOUCH_ONE, t1);
    cal_write(REG_TOUCH_TWO, t2);
    cal_write(REG_TOUCH_THREE, t3);
    check_readback();
  endtask

  // wait until every offered request has been mapped and checked
  task automatic drain();
    @(posedge clk);
    while (sample_queue.size() != 0 || sample_valid || mapped_q.size() != 0) @(posedge clk);
  endtask

  // request sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        sample <= sample_queue.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result stall pattern, plus one long hold-off on request
  flow_t flow_mode = FLOW_OPEN;
  int    flow_left = 0;
  int    hold_left = 0;
  logic  hold_seen = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(16, 80);
      end else begin
        flow_left--;
      end
      case (flow_mode)
        FLOW_OPEN:   result_stall <= 1'b0;
        FLOW_CHOPPY: result_stall <= 1'($urandom_range(0, 1));
        default:     result_stall <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // accept tracking and result checking
  always @(posedge clk) begin : result_check
    out_req_t want;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) mapped_q.push_back(map_sample(sample));
      if (result_valid && !result_stall) begin
        if (mapped_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, got %h", $time, result);
        end else begin
          want = mapped_q.pop_front();
          if (result.screen_x !== want.screen_x) begin
            errors++;
            $display("%0t: screen_x expected %0d got %0d", $time, want.screen_x,
                     result.screen_x);
          end
          if (result.screen_y !== want.screen_y) begin
            errors++;
            $display("%0t: screen_y expected %0d got %0d", $time, want.screen_y,
                     result.screen_y);
          end
          if (result.degenerate !== want.degenerate) begin
            errors++;
            $display("%0t: degenerate expected %b got %b", $time, want.degenerate,
                     result.degenerate);
          end
          if (result.saturated !== want.saturated) begin
            errors++;
            $display("%0t: saturated expected %b got %b", $time, want.saturated,
                     result.saturated);
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    int n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [REG_W-1:0] cfg [NUM_REGS];
    int               ph, k, n, px, py, bx, by;
    cal_regs[REG_PANEL_ONE]   = REG_W'(0);
    cal_regs[REG_PANEL_TWO]   = REG_W'(4095);
    cal_regs[REG_PANEL_THREE] = REG_W'(16773120);
    cal_regs[REG_TOUCH_ONE]   = REG_W'(0);
    cal_regs[REG_TOUCH_TWO]   = REG_W'(4095);
    cal_regs[REG_TOUCH_THREE] = REG_W'(16773120);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity map out of reset, field extremes
    check_readback();
    sample_queue.push_back(raw_req(0, 0));
    sample_queue.push_back(raw_req(COORD_MAX, COORD_MAX));
    sample_queue.push_back(raw_req(COORD_MAX, 0));
    sample_queue.push_back(raw_req(0, COORD_MAX));
    sample_queue.push_back(raw_req(1, 1));
    sample_queue.push_back(raw_req(2048, 2048));
    sample_queue.push_back(raw_req('haaa, 'h555));
    sample_queue.push_back(raw_req('h555, 'haaa));
    drain();

    // all-ones registers: collinear touch points; stray writes past the file
    load_calibration('1, '1, '1, '1, '1, '1);
    cal_write(REG_UNUSED_A, REG_W'($urandom));
    cal_write(REG_UNUSED_B, REG_W'($urandom));
    check_readback();
    sample_queue.push_back(raw_req(COORD_MAX, 0));
    sample_queue.push_back(raw_req(0, COORD_MAX));
    drain();

    // all-zero registers, degenerate as well
    load_calibration('0, '0, '0, '0, '0, '0);
    sample_queue.push_back(raw_req(COORD_MAX, COORD_MAX));
    sample_queue.push_back(raw_req(7, 9));
    drain();

    // unit touch triangle, high gain: positive clamp edge
    load_calibration(cal_point(0, 0), cal_point(COORD_MAX, 0), cal_point(0, COORD_MAX),
                     cal_point(0, 0), cal_point(1, 0), cal_point(0, 1));
    sample_queue.push_back(raw_req(COORD_MAX, COORD_MAX));
    sample_queue.push_back(raw_req(0, 0));
    sample_queue.push_back(raw_req(8, 8));
    sample_queue.push_back(raw_req(9, 0));
    drain();

    // mirrored panel: negative clamp edge
    load_calibration(cal_point(COORD_MAX, COORD_MAX), cal_point(0, COORD_MAX),
                     cal_point(COORD_MAX, 0),
                     cal_point(0, 0), cal_point(1, 0), cal_point(0, 1));
    sample_queue.push_back(raw_req(COORD_MAX, COORD_MAX));
    sample_queue.push_back(raw_req(9, 9));
    sample_queue.push_back(raw_req(10, 10));
    sample_queue.push_back(raw_req(0, 0));
    drain();

    // swapped axes, negative delta, inexact quotients
    load_calibration(cal_point(0, 0), cal_point(100, 0), cal_point(0, 100),
                     cal_point(0, 0), cal_point(0, 7), cal_point(7, 0));
    sample_queue.push_back(raw_req(3, 5));
    sample_queue.push_back(raw_req(COORD_MAX, 1));
    drain();

    // random calibrations with random samples
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      for (k = 0; k < 3; k++) begin
        px = $urandom_range(0, COORD_MAX);
        py = $urandom_range(0, COORD_MAX);
        cfg[REG_PANEL_ONE + k] = cal_point(px, py);
        case (ph % 3)
          0: cfg[REG_TOUCH_ONE + k] =
               cal_point(jitter(px * 3 / 4 + 400, 250), jitter(py * 3 / 4 + 400, 250));
          1: cfg[REG_TOUCH_ONE + k] = REG_W'($urandom);
          default: begin
            // small touch triangle: high gain, sometimes collinear
            if (k == 0) begin
              bx = $urandom_range(0, COORD_MAX);
              by = $urandom_range(0, COORD_MAX);
            end
            cfg[REG_TOUCH_ONE + k] = cal_point(jitter(bx, 12), jitter(by, 12));
            if (k == 2 && $urandom_range(0, 2) == 0) cfg[REG_TOUCH_THREE] = cfg[REG_TOUCH_ONE];
          end
        endcase
      end
      load_calibration(cfg[REG_PANEL_ONE], cfg[REG_PANEL_TWO], cfg[REG_PANEL_THREE],
                       cfg[REG_TOUCH_ONE], cfg[REG_TOUCH_TWO], cfg[REG_TOUCH_THREE]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        sample_queue.push_back(raw_req(rand_raw(), rand_raw()));
      end
      // first random phase: result side holds off so the pipe backs up
      if (ph == 0) hold_go = 1'b1;
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
